>>> rtl/crank_cadence_from_csc_packet_defines.svh
// Assertion helpers for the blocks that check themselves.
`ifndef CRANK_CADENCE_FROM_CSC_PACKET_DEFINES_SVH
`define CRANK_CADENCE_FROM_CSC_PACKET_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CCC_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("ccc implication check failed");

// next-cycle implication, checked out of reset
`define CCC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("ccc next-cycle check failed");

`endif

>>> rtl/ccc_pkg.sv
`default_nettype none
package ccc_pkg;

    localparam int CCC_QUEUE_DEPTH = 2;

    localparam logic [17:0] TPM_RESET   = 18'd61440;
    localparam logic [7:0]  STALE_RESET = 8'd5;

    // register word index (paddr[2])
    localparam logic REG_TPM   = 1'b0;
    localparam logic REG_STALE = 1'b1;

    localparam logic [3:0] OFS_NO_WHEEL   = 4'd1;
    localparam logic [3:0] OFS_WITH_WHEEL = 4'd7;
    localparam logic [3:0] POS_MAX        = 4'd15;

    localparam int FLAG_WHEEL_BIT = 0;
    localparam int FLAG_CRANK_BIT = 1;

    localparam logic [2:0] STAT_UPDATED  = 3'd0;
    localparam logic [2:0] STAT_HELD     = 3'd1;
    localparam logic [2:0] STAT_STALE    = 3'd2;
    localparam logic [2:0] STAT_NO_CRANK = 3'd3;
    localparam logic [2:0] STAT_SHORT    = 3'd4;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] cadence_rpm;
        logic [2:0] status;
    } t_out_word;

    // one finished packet, as handed from front to back
    typedef struct packed {
        logic        crank;
        logic        short_pkt;
        logic [15:0] revs;
        logic [15:0] evt_time;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_CHK,
        BK_DIV,
        BK_EMIT
    } t_back_state;

endpackage
`default_nettype wire

>>> rtl/ccc_front.sv
`default_nettype none
module ccc_front
    import ccc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_word i_in_word,
    input  wire t_q_stat  i_q_stat,
    output logic          o_push,
    output t_job          o_job
);

    logic [3:0]  r_pos,   n_pos;
    logic [7:0]  r_flags, n_flags;
    logic [15:0] r_revs,  n_revs;
    logic [15:0] r_time,  n_time;
    logic [3:0]  w_base;
    logic        w_accept;

    assign o_in_stall = i_q_stat.full;
    assign w_accept   = i_in_valid && !i_q_stat.full;

    always_comb begin
        n_pos   = r_pos;
        n_flags = r_flags;
        n_revs  = r_revs;
        n_time  = r_time;
        if (w_accept && r_pos == 4'd0) begin
            n_flags = i_in_word.byte_value;
        end
        w_base = n_flags[FLAG_WHEEL_BIT] ? OFS_WITH_WHEEL : OFS_NO_WHEEL;
        if (w_accept && r_pos != 4'd0) begin
            if (r_pos == w_base) begin
                n_revs[7:0] = i_in_word.byte_value;
            end else if (r_pos == w_base + 4'd1) begin
                n_revs[15:8] = i_in_word.byte_value;
            end else if (r_pos == w_base + 4'd2) begin
                n_time[7:0] = i_in_word.byte_value;
            end else if (r_pos == w_base + 4'd3) begin
                n_time[15:8] = i_in_word.byte_value;
            end
        end
        if (w_accept) begin
            if (i_in_word.last_byte) begin
                n_pos = 4'd0;
            end else if (r_pos != POS_MAX) begin
                n_pos = r_pos + 4'd1;
            end
        end
        o_push          = w_accept && i_in_word.last_byte;
        o_job.crank     = n_flags[FLAG_CRANK_BIT];
        // fewer than base+4 bytes means the time field never completed
        o_job.short_pkt = r_pos < (w_base + 4'd3);
        o_job.revs      = n_revs;
        o_job.evt_time  = n_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_flags <= '0;
            r_revs  <= '0;
            r_time  <= '0;
        end else begin
            r_pos   <= n_pos;
            r_flags <= n_flags;
            r_revs  <= n_revs;
            r_time  <= n_time;
        end
    end

endmodule
`default_nettype wire

>>> rtl/ccc_queue.sv
`default_nettype none
module ccc_queue
    import ccc_pkg::*;
#(
    parameter int DEPTH = CCC_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_job,
    output t_q_stat   o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_push, w_pop;

    assign o_stat.full  = (r_cnt == FULL_CNT);
    assign o_stat.empty = (r_cnt == '0);
    assign o_job        = r_mem[r_rd];
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule
`default_nettype wire

>>> rtl/ccc_back.sv
`default_nettype none
module ccc_back
    import ccc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [17:0] i_tpm,
    input  wire logic [7:0]  i_stale_limit,
    input  wire t_job        i_job,
    input  wire t_q_stat     i_q_stat,
    output logic             o_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_word        o_out_word
);

    t_back_state r_state, n_state;

    logic [15:0] r_prev_revs, n_prev_revs;
    logic [15:0] r_prev_time, n_prev_time;
    logic [7:0]  r_cadence,   n_cadence;
    logic [7:0]  r_stale,     n_stale;
    logic        r_out_valid, n_out_valid;
    t_out_word   r_out_word,  n_out_word;

    logic [15:0] r_cur_revs, n_cur_revs;
    logic [15:0] r_cur_time, n_cur_time;
    logic [15:0] r_dt,  n_dt;
    logic [15:0] r_dr,  n_dr;
    logic [33:0] r_num, n_num;
    logic [23:0] r_rem, n_rem;
    logic [7:0]  r_quo, n_quo;
    logic [2:0]  r_cnt, n_cnt;
    logic [2:0]  r_stat, n_stat;

    logic [15:0] w_dt, w_dr;
    logic [23:0] w_sub;
    logic        w_bit;
    logic        w_out_free;

    assign w_dt       = i_job.evt_time - r_prev_time;
    assign w_dr       = i_job.revs - r_prev_revs;
    assign w_sub      = {8'd0, r_dt} << r_cnt;
    assign w_bit      = (r_rem >= w_sub);
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        n_state     = r_state;
        n_prev_revs = r_prev_revs;
        n_prev_time = r_prev_time;
        n_cadence   = r_cadence;
        n_stale     = r_stale;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        n_cur_revs  = r_cur_revs;
        n_cur_time  = r_cur_time;
        n_dt        = r_dt;
        n_dr        = r_dr;
        n_num       = r_num;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_stat      = r_stat;
        o_pop       = 1'b0;

        case (r_state)
            BK_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop      = 1'b1;
                    n_cur_revs = i_job.revs;
                    n_cur_time = i_job.evt_time;
                    n_dt       = w_dt;
                    n_dr       = w_dr;
                    n_state    = BK_EMIT;
                    if (!i_job.crank) begin
                        n_stat = STAT_NO_CRANK;
                    end else if (i_job.short_pkt) begin
                        n_stat = STAT_SHORT;
                    end else if (w_dt != 16'd0) begin
                        n_state = BK_MUL;
                    end else if (r_stale <= i_stale_limit) begin
                        if (r_stale != 8'hFF) begin
                            n_stale = r_stale + 8'd1;
                        end
                        n_stat = STAT_HELD;
                    end else begin
                        n_cadence = 8'd0;
                        n_stat    = STAT_STALE;
                    end
                end
            end
            BK_MUL: begin
                n_num   = {18'd0, r_dr} * {16'd0, i_tpm};
                n_state = BK_CHK;
            end
            BK_CHK: begin
                // quotient above 255 saturates; otherwise remainder fits 24 bits
                if (r_num >= {10'd0, r_dt, 8'd0}) begin
                    n_cadence   = 8'hFF;
                    n_stale     = 8'd0;
                    n_prev_revs = r_cur_revs;
                    n_prev_time = r_cur_time;
                    n_stat      = STAT_UPDATED;
                    n_state     = BK_EMIT;
                end else begin
                    n_rem   = r_num[23:0];
                    n_quo   = 8'd0;
                    n_cnt   = 3'd7;
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                if (w_bit) begin
                    n_rem = r_rem - w_sub;
                end
                n_quo = {r_quo[6:0], w_bit};
                n_cnt = r_cnt - 3'd1;
                if (r_cnt == 3'd0) begin
                    n_cadence   = {r_quo[6:0], w_bit};
                    n_stale     = 8'd0;
                    n_prev_revs = r_cur_revs;
                    n_prev_time = r_cur_time;
                    n_stat      = STAT_UPDATED;
                    n_state     = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (w_out_free) begin
                    n_out_valid            = 1'b1;
                    n_out_word.cadence_rpm = r_cadence;
                    n_out_word.status      = r_stat;
                    n_state                = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_revs <= '0;
            r_prev_time <= '0;
            r_cadence   <= '0;
            r_stale     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_prev_revs <= n_prev_revs;
            r_prev_time <= n_prev_time;
            r_cadence   <= n_cadence;
            r_stale     <= n_stale;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
        r_cur_revs <= n_cur_revs;
        r_cur_time <= n_cur_time;
        r_dt       <= n_dt;
        r_dr       <= n_dr;
        r_num      <= n_num;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_stat     <= n_stat;
    end

endmodule
`default_nettype wire

>>> rtl/crank_cadence_from_csc_packet.sv
// Crank cadence from CSC measurement packets. Bytes of a packet come in one per word
// with a last-byte mark; each packet yields one result word (cadence in rpm and a
// status code) after its last byte. The front parser takes one byte per cycle while
// the two-entry packet queue has room and stalls every byte while it is full. The back
// end pops a packet and then loads the output when it needs no division; when the
// quotient saturates it pops, does one 16x18 multiply and a saturation compare, then
// loads the output; a full cadence update also forms the 8-bit quotient, one bit per
// cycle, after the compare and before the output load. That bit-serial quotient loop
// sets the packet rate; packets of twelve bytes or more hide it behind the byte
// stream, while shorter packets sent back to back fill the queue and then stall the
// input. Registers: ticks_per_minute at 0x0, staleness_limit at 0x4.
`default_nettype none
`include "crank_cadence_from_csc_packet_defines.svh"
module crank_cadence_from_csc_packet
    import ccc_pkg::*;
#(
    parameter int QUEUE_DEPTH = CCC_QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_word    i_in_word,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_word        o_out_word,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [17:0] r_tpm;
    logic [7:0]  r_stale_limit;
    logic        w_cfg_wr;

    logic    w_push;
    logic    w_pop;
    t_job    w_push_job;
    t_job    w_head_job;
    t_q_stat w_q_stat;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_STALE) ? {24'd0, r_stale_limit} : {14'd0, r_tpm};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpm         <= TPM_RESET;
            r_stale_limit <= STALE_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_TPM) begin
                r_tpm <= pwdata[17:0];
            end else begin
                r_stale_limit <= pwdata[7:0];
            end
        end
    end

    ccc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    ccc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_stat  (w_q_stat)
    );

    ccc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tpm         (r_tpm),
        .i_stale_limit (r_stale_limit),
        .i_job         (w_head_job),
        .i_q_stat      (w_q_stat),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_word    (o_out_word)
    );

    `CCC_ASSERT_IMPL(a_push_has_room, i_clk, i_rst_n, w_push, !w_q_stat.full)
    `CCC_ASSERT_IMPL(a_pop_has_data, i_clk, i_rst_n, w_pop, !w_q_stat.empty)
    `CCC_ASSERT_IMPL(a_stale_reads_zero, i_clk, i_rst_n, o_out_valid && (o_out_word.status == STAT_STALE), o_out_word.cadence_rpm == 8'd0)
    `CCC_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, w_push && !w_pop, !w_q_stat.empty)

endmodule
`default_nettype wire
